// ===== rtl/tbs_pkg.sv =====
// Package for the tile batch splitter: item types, register indexes and
// sizing constants shared by the interfaces, the divider and the top level.
// No dependencies.
package tbs_pkg;

    localparam int unsigned DIV_BITS    = 32;
    localparam int unsigned DIV_DIGIT   = 2;
    localparam int unsigned DIV_CYCLES  = DIV_BITS / DIV_DIGIT;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_CYCLES);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_ONE  = DIV_CNT_W'(1);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    localparam int unsigned CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd2;

    localparam logic [15:0] GRID_WIDTH_RST  = 16'd1024;
    localparam logic [15:0] TILE_WIDTH_RST  = 16'd256;
    localparam logic [15:0] TILE_HEIGHT_RST = 16'd256;

    localparam logic [24:0] COUNT_MAX = 25'd16777216;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_BATCH = 1'b1;

    typedef struct packed {
        logic        point_valid;
        logic [31:0] tile_id;
        logic [31:0] cell_id;
        logic        end_of_set;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [31:0] local_cell;
        logic [15:0] row_of_tile;
        logic [15:0] col_of_tile;
        logic [23:0] batch_first;
        logic [24:0] batch_count;
        logic        last;
    } t_out_item;

endpackage

// ===== rtl/tbs_intf.sv =====
// Handshake interfaces of the tile batch splitter: point input, result output
// and configuration write channel. Depends on tbs_pkg.
interface tbs_in_if;
    logic              valid;
    logic              ready;
    tbs_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbs_out_if;
    logic               valid;
    logic               ready;
    tbs_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tbs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbs_pkg::CFG_IDX_W-1:0]   index;
    logic [15:0]                     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tbs_div.sv =====
// Digit-serial unsigned divider, 32-bit dividend by 16-bit divisor, two
// quotient bits per cycle through a shift register. Depends on tbs_pkg.
module tbs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient,
    output logic [15:0] o_remainder
);

    logic [31:0]                   r_sh;
    logic [15:0]                   r_rem;
    logic [15:0]                   r_div;
    logic [tbs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;

    logic [16:0] step1;
    logic [16:0] step2;
    logic [31:0] n_sh;

    // One restoring step: the partial remainder stays below the divisor,
    // so it always fits in 16 bits after the subtraction.
    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic        bit_in,
                                             input logic [15:0] d);
        logic [16:0] t;
        logic [16:0] t_sub;
        begin
            t     = {rem, bit_in};
            t_sub = t - {1'b0, d};
            if (t >= {1'b0, d}) begin
                div_step = {t_sub[15:0], 1'b1};
            end else begin
                div_step = {t[15:0], 1'b0};
            end
        end
    endfunction

    always_comb begin
        step1 = div_step(r_rem, r_sh[31], r_div);
        step2 = div_step(step1[16:1], r_sh[30], r_div);
        n_sh  = {r_sh[29:0], step1[0], step2[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_sh   <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_sh  <= n_sh;
            r_rem <= step2[16:1];
            r_cnt <= r_cnt + tbs_pkg::DIV_CNT_ONE;
            if (r_cnt == tbs_pkg::DIV_CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_sh;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/tile_batch_splitter_local_index_core.sv =====
// Top level of the tile batch splitter with local cell index.
// Depends on tbs_pkg, the interfaces in tbs_intf and the divider tbs_div.
//
// Usage: points sorted by tile arrive on i_in, one item each, and results
// leave on o_out; kind 0 is a point's local cell index, kind 1 the record of
// a closed batch, and last marks the final result of one input item. Each
// input item gives zero to three results. Registers (grid width, tile width,
// tile height, at indexes 0 to 2) are written on i_cfg, which is always
// ready and should be written only while the block is idle.
// Flow: an item is taken in S_IDLE, prepared in S_PREP and divided in S_DIV
// by three dividers side by side (tile by tiles across, previous batch tile
// likewise, cell by grid width), which S_DIV waits to see finish. The
// multiply states and then S_EMIT, which hands over the results, follow.
// For the first item after reset or a write of grid width or tile width,
// S_ACROSS first waits for tiles across from the cell divider before the rest.
// Reset restores the register defaults, closes any batch and clears the set
// position. Results go through one output register; while the receiver
// stalls the block finishes its work and waits, and it takes the next item
// once the last result of the current one sits in that register.
module tile_batch_splitter_local_index_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tbs_cfg_if.sink         i_cfg,
    tbs_in_if.sink          i_in,
    tbs_out_if.source       o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ACROSS,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration.
    logic [15:0] r_gw;
    logic [15:0] r_tw;
    logic [15:0] r_th;
    logic [15:0] r_across;
    logic        r_dirty;

    // Batch state.
    logic        r_open;
    logic [31:0] r_open_tile;
    logic [23:0] r_first;
    logic [24:0] r_count;
    logic [23:0] r_pos;

    // Item being worked on.
    logic [31:0] r_tile;
    logic [31:0] r_cell;
    logic [31:0] r_prev_tile;
    logic [23:0] r_pf;
    logic [24:0] r_pc;
    logic [23:0] r_ef;
    logic [24:0] r_ec;
    logic [2:0]  r_pend;
    logic [31:0] r_y0;
    logic [31:0] r_x0;
    logic [31:0] r_dy;
    logic [31:0] r_dx;
    logic [15:0] r_aw;
    logic [31:0] r_local;

    tbs_pkg::t_out_item r_out;
    logic               r_ov;

    logic [15:0] gw_eff;
    logic [15:0] tw_eff;
    logic [16:0] across_num;

    logic        start_a;
    logic        start_c;
    logic        busy_a;
    logic        busy_b;
    logic        busy_c;
    logic [31:0] quo_a;
    logic [31:0] quo_b;
    logic [31:0] quo_c;
    logic [15:0] rem_a;
    logic [15:0] rem_b;
    logic [15:0] rem_c;
    logic [31:0] div_c_num;
    logic [15:0] div_c_den;

    logic        accept;
    logic        close_prev;
    logic        close_eos;
    logic        n_open;
    logic [31:0] n_open_tile;
    logic [23:0] n_first;
    logic [24:0] n_count;
    logic [23:0] n_pos;
    logic [23:0] eos_first;
    logic [24:0] eos_count;

    logic [47:0] y0_full;
    logic [31:0] x0_full;
    logic [31:0] room;
    logic [47:0] loc_full;

    logic               out_free;
    logic               emit_now;
    tbs_pkg::t_out_item n_out;
    logic [2:0]         n_pend;

    assign gw_eff     = (r_gw == 16'd0) ? 16'd1 : r_gw;
    assign tw_eff     = (r_tw == 16'd0) ? 16'd1 : r_tw;
    assign across_num = {1'b0, gw_eff} + {1'b0, tw_eff} - 17'd1;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && (r_state == S_IDLE);

    // The tiles-across division borrows the cell divider.
    assign start_a   = (r_state == S_PREP && !r_dirty) ||
                       (r_state == S_ACROSS && !busy_c);
    assign start_c   = (r_state == S_PREP) || (r_state == S_ACROSS && !busy_c);
    assign div_c_num = (r_state == S_PREP && r_dirty) ? {15'd0, across_num} : r_cell;
    assign div_c_den = (r_state == S_PREP && r_dirty) ? tw_eff : gw_eff;

    tbs_div u_div_tile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start_a),
        .i_dividend  (r_tile),
        .i_divisor   ((r_state == S_ACROSS) ? quo_c[15:0] : r_across),
        .o_busy      (busy_a),
        .o_quotient  (quo_a),
        .o_remainder (rem_a)
    );

    tbs_div u_div_prev (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start_a),
        .i_dividend  (r_prev_tile),
        .i_divisor   ((r_state == S_ACROSS) ? quo_c[15:0] : r_across),
        .o_busy      (busy_b),
        .o_quotient  (quo_b),
        .o_remainder (rem_b)
    );

    tbs_div u_div_cell (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start_c),
        .i_dividend  (div_c_num),
        .i_divisor   (div_c_den),
        .o_busy      (busy_c),
        .o_quotient  (quo_c),
        .o_remainder (rem_c)
    );

    // Batch bookkeeping for the item on the input channel.
    always_comb begin
        close_prev  = r_open && (!i_in.data.point_valid ||
                                 i_in.data.tile_id != r_open_tile);
        n_open      = r_open && !close_prev;
        n_open_tile = r_open_tile;
        n_first     = r_first;
        n_count     = r_count;
        if (i_in.data.point_valid) begin
            if (!n_open) begin
                n_open      = 1'b1;
                n_open_tile = i_in.data.tile_id;
                n_first     = r_pos;
                n_count     = '0;
            end
            if (n_count < tbs_pkg::COUNT_MAX) begin
                n_count = n_count + 25'd1;
            end
        end
        close_eos = i_in.data.end_of_set && n_open;
        eos_first = n_first;
        eos_count = n_count;
        if (close_eos) begin
            n_open = 1'b0;
        end
        if (i_in.data.end_of_set) begin
            n_pos   = '0;
            n_first = '0;
            n_count = '0;
        end else begin
            n_pos = r_pos + 24'd1;
        end
    end

    // Local index arithmetic.
    always_comb begin
        y0_full  = quo_a * r_th;
        x0_full  = rem_a * tw_eff;
        room     = {16'd0, gw_eff} - r_x0;
        loc_full = r_dy * r_aw;
    end

    // Result selection: previous batch record, point, end-of-set record.
    assign out_free = !r_ov || o_out.ready;
    assign emit_now = (r_state == S_EMIT) && (r_pend != 3'b000) && out_free;

    always_comb begin
        n_out  = '0;
        n_pend = r_pend;
        if (r_pend[0]) begin
            n_out.kind        = tbs_pkg::KIND_BATCH;
            n_out.row_of_tile = quo_b[15:0];
            n_out.col_of_tile = rem_b;
            n_out.batch_first = r_pf;
            n_out.batch_count = r_pc;
            n_out.last        = (r_pend[2:1] == 2'b00);
            n_pend[0]         = 1'b0;
        end else if (r_pend[1]) begin
            n_out.kind        = tbs_pkg::KIND_POINT;
            n_out.local_cell  = r_local;
            n_out.row_of_tile = quo_a[15:0];
            n_out.col_of_tile = rem_a;
            n_out.last        = !r_pend[2];
            n_pend[1]         = 1'b0;
        end else begin
            n_out.kind        = tbs_pkg::KIND_BATCH;
            n_out.row_of_tile = quo_a[15:0];
            n_out.col_of_tile = rem_a;
            n_out.batch_first = r_ef;
            n_out.batch_count = r_ec;
            n_out.last        = 1'b1;
            n_pend[2]         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gw        <= tbs_pkg::GRID_WIDTH_RST;
            r_tw        <= tbs_pkg::TILE_WIDTH_RST;
            r_th        <= tbs_pkg::TILE_HEIGHT_RST;
            r_dirty     <= 1'b1;
            r_open      <= 1'b0;
            r_open_tile <= '0;
            r_first     <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_pend      <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    tbs_pkg::CFG_GRID_WIDTH: begin
                        r_gw    <= i_cfg.data;
                        r_dirty <= 1'b1;
                    end
                    tbs_pkg::CFG_TILE_WIDTH: begin
                        r_tw    <= i_cfg.data;
                        r_dirty <= 1'b1;
                    end
                    tbs_pkg::CFG_TILE_HEIGHT: begin
                        r_th <= i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end

            if (emit_now) begin
                r_out <= n_out;
                r_ov  <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tile      <= i_in.data.tile_id;
                        r_cell      <= i_in.data.cell_id;
                        r_prev_tile <= r_open_tile;
                        r_pf        <= r_first;
                        r_pc        <= r_count;
                        r_ef        <= eos_first;
                        r_ec        <= eos_count;
                        r_pend      <= {close_eos, i_in.data.point_valid, close_prev};
                        r_open      <= n_open;
                        r_open_tile <= n_open_tile;
                        r_first     <= n_first;
                        r_count     <= n_count;
                        r_pos       <= n_pos;
                        r_state     <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= r_dirty ? S_ACROSS : S_DIV;
                end
                S_ACROSS: begin
                    if (!busy_c) begin
                        r_across <= quo_c[15:0];
                        r_dirty  <= 1'b0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!busy_a && !busy_b && !busy_c) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_y0    <= y0_full[31:0];
                    r_x0    <= x0_full;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // The tile's width is clipped where the grid ends.
                    r_aw    <= ({16'd0, tw_eff} < room) ? tw_eff : room[15:0];
                    r_dy    <= quo_c - r_y0;
                    r_dx    <= {16'd0, rem_c} - r_x0;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_local <= loc_full[31:0] + r_dx;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_pend == 3'b000) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_pend <= n_pend;
                        if (n_pend == 3'b000) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

endmodule
